// ----- design/prce_pkg.sv -----
// Package for the residue code extractor: constants, job record, code table.
// No dependencies; used by every module of the block by scoped name.
package prce_pkg;

    localparam int BYTE_W      = 8;
    localparam int COL_W       = 5;
    localparam int PROG_W      = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int TABLE_LEN   = 26;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] SPACE   = 8'd32;
    localparam logic [COL_W-1:0]  RES_COL   = 5'd17;
    localparam logic [COL_W-1:0]  CHAIN_COL = 5'd21;
    localparam logic [COL_W-1:0]  COL_SAT   = 5'd22;
    localparam logic [PROG_W-1:0] KEY_LEN   = 3'd6;

    localparam logic [BYTE_W-1:0]     CHAIN_RESET = 8'd65;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAIN  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ABBREV = 1'd1;

    typedef enum logic [1:0] {
        JOB_THREE,
        JOB_ONE,
        JOB_ERR
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [BYTE_W-1:0] ch0;   // residue byte 0, or one-letter code
        logic [BYTE_W-1:0] ch1;
        logic [BYTE_W-1:0] ch2;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] code;
    } t_lookup;

    // residue name in [31:8], one-letter code in [7:0]
    localparam logic [31:0] CODE_TABLE [TABLE_LEN] = '{
        "ALAA", "ARGR", "ASNN", "ASPD", "CYSC", "GLNQ", "GLUE", "GLYG",
        "HISH", "ILEI", "LEUL", "LYSK", "METM", "PHEF", "PROP", "PYLO",
        "SERS", "SECU", "THRT", "TRPW", "TYRY", "VALV", "ASXB", "GLXZ",
        "ZAAX", "XLEJ"
    };

    function automatic logic [BYTE_W-1:0] keyword_byte(input logic [PROG_W-1:0] p);
        logic [BYTE_W-1:0] b;
        unique case (p)
            3'd0:    b = "A";
            3'd1:    b = "T";
            3'd2:    b = "O";
            3'd3:    b = "M";
            3'd4:    b = " ";
            3'd5:    b = " ";
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic t_lookup lookup_code(input logic [23:0] name);
        t_lookup r;
        r.hit  = 1'b0;
        r.code = '0;
        for (int i = 0; i < TABLE_LEN; i++) begin
            if (CODE_TABLE[i][31:8] == name) begin
                r.hit  = 1'b1;
                r.code = CODE_TABLE[i][7:0];
            end
        end
        return r;
    endfunction

endpackage

// ----- design/prce_front.sv -----
// Front end: column tracking, keyword search, residue/chain capture, lookup.
// Depends on prce_pkg; hands one job per emitting line to the queue.
module prce_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [prce_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [prce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_accept,
    input  logic [prce_pkg::BYTE_W-1:0]     i_text_byte,
    input  logic                            i_file_end,
    output logic                            o_push,
    output prce_pkg::t_job                  o_job
);

    logic [prce_pkg::BYTE_W-1:0] r_chain_select;
    logic                        r_abbrev;
    logic [prce_pkg::COL_W-1:0]  r_col,   n_col;
    logic [prce_pkg::PROG_W-1:0] r_prog,  n_prog;
    logic                        r_seen,  n_seen;
    logic [prce_pkg::BYTE_W-1:0] r_res [3];
    logic [prce_pkg::BYTE_W-1:0] n_res [3];
    logic                        r_chain, n_chain;
    logic                        r_err,   n_err;

    logic                        is_nl, line_end, emit;
    logic [prce_pkg::PROG_W-1:0] p;
    prce_pkg::t_lookup           lk;

    always_comb begin
        is_nl    = (i_text_byte == prce_pkg::NEWLINE);
        line_end = is_nl || i_file_end;
        n_col    = r_col;
        n_prog   = r_prog;
        n_seen   = r_seen;
        n_res    = r_res;
        n_chain  = r_chain;
        p        = r_prog;
        if (!is_nl) begin
            if (r_col >= prce_pkg::RES_COL && r_col < prce_pkg::RES_COL + 5'd3)
                n_res[2'(r_col - prce_pkg::RES_COL)] = i_text_byte;
            if (r_col == prce_pkg::CHAIN_COL)
                n_chain = (i_text_byte == r_chain_select);
            if (r_col < prce_pkg::COL_SAT)
                n_col = r_col + 5'd1;
            if (!r_seen) begin
                if (i_text_byte == prce_pkg::keyword_byte(r_prog))
                    p = r_prog + 3'd1;
                else
                    p = (i_text_byte == prce_pkg::keyword_byte(3'd0)) ? 3'd1 : 3'd0;
                if (p >= prce_pkg::KEY_LEN) begin
                    n_seen = 1'b1;
                    p      = 3'd0;
                end
                n_prog = p;
            end
        end

        lk   = prce_pkg::lookup_code({n_res[0], n_res[1], n_res[2]});
        emit = n_seen && n_chain && !r_err;

        o_job.ch0 = n_res[0];
        o_job.ch1 = n_res[1];
        o_job.ch2 = n_res[2];
        if (!r_abbrev)
            o_job.kind = prce_pkg::JOB_THREE;
        else if (lk.hit) begin
            o_job.kind = prce_pkg::JOB_ONE;
            o_job.ch0  = lk.code;
        end else
            o_job.kind = prce_pkg::JOB_ERR;

        o_push = i_accept && line_end && emit;

        n_err = r_err;
        if (o_push && o_job.kind == prce_pkg::JOB_ERR)
            n_err = 1'b1;
        if (i_file_end)
            n_err = 1'b0;

        if (line_end) begin
            n_col   = '0;
            n_prog  = '0;
            n_seen  = 1'b0;
            n_res   = '{default: '0};
            n_chain = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_select <= prce_pkg::CHAIN_RESET;
            r_abbrev       <= 1'b0;
            r_col          <= '0;
            r_prog         <= '0;
            r_seen         <= 1'b0;
            r_res          <= '{default: '0};
            r_chain        <= 1'b0;
            r_err          <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                if (i_cfg_index == prce_pkg::REG_CHAIN)
                    r_chain_select <= i_cfg_data;
                else if (i_cfg_index == prce_pkg::REG_ABBREV)
                    r_abbrev <= i_cfg_data[0];
            end
            if (i_accept) begin
                r_col   <= n_col;
                r_prog  <= n_prog;
                r_seen  <= n_seen;
                r_res   <= n_res;
                r_chain <= n_chain;
                r_err   <= n_err;
            end
        end
    end

endmodule

// ----- design/prce_queue.sv -----
// Job queue between front and back end, register based.
// Depends on prce_pkg for the job record and depth.
module prce_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  prce_pkg::t_job          i_job,
    input  logic                    i_pop,
    output prce_pkg::t_job          o_head,
    output prce_pkg::t_queue_status o_status
);

    prce_pkg::t_job              r_slot [prce_pkg::QUEUE_DEPTH];
    logic [prce_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [prce_pkg::QCNT_W-1:0] r_count;

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == prce_pkg::QCNT_W'(prce_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_slot[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= r_wr_ptr + prce_pkg::QPTR_W'(1);
            if (i_pop)
                r_rd_ptr <= r_rd_ptr + prce_pkg::QPTR_W'(1);
            if (i_push && !i_pop)
                r_count <= r_count + prce_pkg::QCNT_W'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - prce_pkg::QCNT_W'(1);
        end
    end

endmodule

// ----- design/prce_back.sv -----
// Back end: expands a queued job into one to four output bytes.
// Depends on prce_pkg; output register with valid/ready towards the sink.
module prce_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prce_pkg::t_job              i_head,
    input  prce_pkg::t_queue_status     i_status,
    output logic                        o_pop,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [prce_pkg::BYTE_W-1:0] o_out_char,
    output logic                        o_lookup_error,
    output logic                        o_run_last
);

    logic [1:0]                  r_idx;
    logic                        r_valid;
    logic [prce_pkg::BYTE_W-1:0] r_char;
    logic                        r_err, r_last;

    logic                        load, last;
    logic [prce_pkg::BYTE_W-1:0] ch;
    logic                        err;

    always_comb begin
        ch  = prce_pkg::SPACE;
        err = 1'b0;
        unique case (i_head.kind)
            prce_pkg::JOB_THREE: begin
                last = (r_idx == 2'd3);
                unique case (r_idx)
                    2'd0:    ch = i_head.ch0;
                    2'd1:    ch = i_head.ch1;
                    2'd2:    ch = i_head.ch2;
                    default: ch = prce_pkg::SPACE;
                endcase
            end
            prce_pkg::JOB_ONE: begin
                last = (r_idx == 2'd1);
                ch   = (r_idx == 2'd0) ? i_head.ch0 : prce_pkg::SPACE;
            end
            default: begin
                last = 1'b1;
                ch   = '0;
                err  = 1'b1;
            end
        endcase
        load  = !i_status.empty && (!r_valid || i_ready);
        o_pop = load && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready)
                r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= ch;
            r_err  <= err;
            r_last <= last;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_char     = r_char;
    assign o_lookup_error = r_err;
    assign o_run_last     = r_last;

endmodule

// ----- design/pdb_residue_code_extractor_top.sv -----
// Top level of the residue code extractor: front end, job queue, back end.
// Depends on prce_pkg, prce_front, prce_queue and prce_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | i_valid / o_ready  | i_text_byte, i_file_end
//  output   | o_valid / i_ready  | o_out_char, o_lookup_error, o_run_last
//  config   | i_cfg_wen          | i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while o_ready is high; a line's job is registered
// in the queue, then in the output register, and leaves one byte per cycle while
// i_ready is high (1 to 4 bytes). Reset is synchronous and clears line state,
// error flag, queue and output. o_ready drops only when the four-entry job
// queue is full, i.e. when the sink has stalled through several emitting lines.
module pdb_residue_code_extractor_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [prce_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [prce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [prce_pkg::BYTE_W-1:0]      i_text_byte,
    input  logic                             i_file_end,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [prce_pkg::BYTE_W-1:0]      o_out_char,
    output logic                             o_lookup_error,
    output logic                             o_run_last
);

    logic                    push, pop;
    prce_pkg::t_job          job, head;
    prce_pkg::t_queue_status q_status;

    assign o_ready = !q_status.full;

    prce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (i_valid && o_ready),
        .i_text_byte (i_text_byte),
        .i_file_end  (i_file_end),
        .o_push      (push),
        .o_job       (job)
    );

    prce_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    prce_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_status       (q_status),
        .o_pop          (pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_out_char     (o_out_char),
        .o_lookup_error (o_lookup_error),
        .o_run_last     (o_run_last)
    );

    // an error result is always alone and carries a zero byte
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_lookup_error |-> o_run_last && o_out_char == '0)
        else $error("error result not final or not zero");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_status.full))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_status.empty))
        else $error("job popped from empty queue");

    // a job pushed into an empty queue while the output register is free or being
    // taken passes through a queue slot and then shows up at the output
    a_job_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && q_status.empty && (!o_valid || i_ready) |=> ##1 o_valid)
        else $error("queued job not forwarded");

endmodule

// ----- sim/prce_test_pkg.sv -----
// Test package for the residue code extractor: residue table, item types and the
// scoreboard that tracks line state and expected output characters.
// Depends on prce_pkg for the register indexes.
package prce_test_pkg;

    localparam logic [7:0]  LF         = 8'd10;
    localparam logic [7:0]  BLANK      = 8'd32;
    localparam logic [47:0] KEYWORD    = "ATOM  ";
    localparam int          NAME_COL   = 17;
    localparam int          CHAIN_COL  = 21;
    localparam int          COL_LIMIT  = 22;
    localparam int          N_RESIDUES = 26;

    localparam logic [23:0] RESIDUE_NAME [N_RESIDUES] = '{
        "ALA", "ARG", "ASN", "ASP", "CYS", "GLN", "GLU", "GLY", "HIS", "ILE",
        "LEU", "LYS", "MET", "PHE", "PRO", "PYL", "SER", "SEC", "THR", "TRP",
        "TYR", "VAL", "ASX", "GLX", "ZAA", "XLE"
    };
    // one-letter codes, same order as the names above
    localparam logic [8*N_RESIDUES-1:0] RESIDUE_LETTER = "ARNDCQEGHILKMFPOSUTWYVBZXJ";

    typedef struct packed {
        logic [7:0] text;
        logic       last_of_file;
    } t_text_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       err;
        logic       last;
    } t_residue_out;

    // {hit, code}
    function automatic logic [8:0] residue_letter(logic [23:0] name);
        for (int i = 0; i < N_RESIDUES; i++) begin
            if (RESIDUE_NAME[i] == name)
                return {1'b1, RESIDUE_LETTER[8*(N_RESIDUES-1-i) +: 8]};
        end
        return 9'd0;
    endfunction

    class residue_scoreboard;
        logic [7:0]   chain_sel;
        logic         one_letter;
        logic [4:0]   column;
        logic [2:0]   key_match;
        logic         key_found;
        logic [7:0]   name_bytes [3];
        logic         chain_hit;
        logic         name_error;
        t_residue_out expected_chars [$];
        int           errors;

        function new();
            chain_sel  = "A";
            one_letter = 1'b0;
            name_error = 1'b0;
            errors     = 0;
            clear_line();
        endfunction

        function void clear_line();
            column    = '0;
            key_match = '0;
            key_found = 1'b0;
            chain_hit = 1'b0;
            for (int i = 0; i < 3; i++)
                name_bytes[i] = '0;
        endfunction

        function void write_reg(logic [prce_pkg::CFG_INDEX_W-1:0] idx,
                                logic [prce_pkg::CFG_DATA_W-1:0] data);
            if (idx == prce_pkg::REG_CHAIN)
                chain_sel = data;
            else if (idx == prce_pkg::REG_ABBREV)
                one_letter = data[0];
        endfunction

        function void take_byte(logic [7:0] b);
            logic [2:0] p;
            if (column >= NAME_COL && column < NAME_COL + 3)
                name_bytes[column - NAME_COL] = b;
            if (column == CHAIN_COL)
                chain_hit = (b == chain_sel);
            if (column < COL_LIMIT)
                column = column + 5'd1;
            if (!key_found) begin
                p = key_match;
                if (b == KEYWORD[47-8*p -: 8])
                    p = p + 3'd1;
                else
                    p = (b == KEYWORD[47:40]) ? 3'd1 : 3'd0;
                if (p == 3'd6) begin
                    key_found = 1'b1;
                    p = '0;
                end
                key_match = p;
            end
        endfunction

        function void close_line();
            logic [8:0] hit_code;
            if (!key_found || !chain_hit || name_error)
                return;
            if (!one_letter) begin
                for (int i = 0; i < 3; i++)
                    expected_chars.push_back(t_residue_out'{name_bytes[i], 1'b0, 1'b0});
                expected_chars.push_back(t_residue_out'{BLANK, 1'b0, 1'b0});
                return;
            end
            hit_code = residue_letter({name_bytes[0], name_bytes[1], name_bytes[2]});
            if (hit_code[8]) begin
                expected_chars.push_back(t_residue_out'{hit_code[7:0], 1'b0, 1'b0});
                expected_chars.push_back(t_residue_out'{BLANK, 1'b0, 1'b0});
            end else begin
                name_error = 1'b1;
                expected_chars.push_back(t_residue_out'{8'd0, 1'b1, 1'b0});
            end
        endfunction

        // called for every accepted input transaction
        function void note_text_byte(logic [7:0] b, logic eof);
            int prior_size;
            prior_size = expected_chars.size();
            if (b != LF)
                take_byte(b);
            if (b == LF || eof) begin
                close_line();
                clear_line();
            end
            if (eof)
                name_error = 1'b0;
            if (expected_chars.size() > prior_size)
                expected_chars[expected_chars.size()-1].last = 1'b1;
        endfunction

        task report(string msg);
            // output capped, count kept
            if (errors < 40)
                $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // called for every accepted output transaction
        task check_emitted_char(logic [7:0] ch, logic err, logic last);
            t_residue_out want;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected output char %02h err %b last %b", ch, err, last));
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch)
                report($sformatf("out_char %02h, expected %02h", ch, want.ch));
            if (err !== want.err)
                report($sformatf("lookup_error %b, expected %b", err, want.err));
            if (last !== want.last)
                report($sformatf("run_last %b, expected %b", last, want.last));
        endtask
    endclass

endpackage

// ----- sim/pdb_residue_code_extractor_top_test.sv -----
// Testbench for pdb_residue_code_extractor_top: directed lines, then random
// structure text under random idling and a long output hold-off.
// Depends on prce_pkg and prce_test_pkg.
module pdb_residue_code_extractor_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prce_test_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef enum int { END_LF, END_LF_EOF, END_EOF, END_OPEN } t_line_end;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wen;
    logic [prce_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [prce_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             i_valid;
    logic                             o_ready;
    logic [prce_pkg::BYTE_W-1:0]      i_text_byte;
    logic                             i_file_end;
    logic                             o_valid;
    logic                             i_ready;
    logic [prce_pkg::BYTE_W-1:0]      o_out_char;
    logic                             o_lookup_error;
    logic                             o_run_last;

    residue_scoreboard sb = new();
    t_text_item        feed_q [$];
    logic              idle_en;
    logic              hold_req;
    logic              hold_done;
    int                quiet_cycles = 0;

    pdb_residue_code_extractor_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .i_file_end     (i_file_end),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_char     (o_out_char),
        .o_lookup_error (o_lookup_error),
        .o_run_last     (o_run_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] filler();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == LF) ? BLANK : b;
    endfunction

    function automatic void push_text(string s, logic eof);
        for (int i = 0; i < s.len(); i++)
            feed_q.push_back(t_text_item'{s[i], eof && i == s.len() - 1});
    endfunction

    // one record line; key_col < 0 leaves the keyword out
    function automatic void add_line(logic [23:0] name, logic [7:0] chain, int key_col,
                                     int len, t_line_end how);
        logic [7:0] row [$];
        for (int c = 0; c < len; c++)
            row.push_back(filler());
        if (key_col >= 0)
            for (int k = 0; k < 6; k++)
                if (key_col + k < len)
                    row[key_col + k] = KEYWORD[47-8*k -: 8];
        if (len > NAME_COL)     row[NAME_COL]     = name[23:16];
        if (len > NAME_COL + 1) row[NAME_COL + 1] = name[15:8];
        if (len > NAME_COL + 2) row[NAME_COL + 2] = name[7:0];
        if (len > CHAIN_COL)    row[CHAIN_COL]    = chain;
        for (int c = 0; c < len; c++)
            feed_q.push_back(t_text_item'{row[c], how == END_EOF && c == len - 1});
        if (how == END_LF || how == END_LF_EOF)
            feed_q.push_back(t_text_item'{LF, how == END_LF_EOF});
    endfunction

    // raw bytes, newlines included
    function automatic void add_noise(int len, t_line_end how);
        for (int i = 0; i < len; i++)
            feed_q.push_back(t_text_item'{8'($urandom_range(0, 255)),
                                          how == END_EOF && i == len - 1});
        if (how != END_EOF || len == 0)
            feed_q.push_back(t_text_item'{LF, how != END_LF});
    endfunction

    function automatic void add_random_line();
        int          pick;
        int          len;
        t_line_end   how;
        logic [23:0] name;
        logic [7:0]  chain;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 19))
            0:       how = END_EOF;
            1:       how = END_LF_EOF;
            default: how = END_LF;
        endcase
        if (pick < 15) begin
            add_noise($urandom_range(0, 30), how);
            return;
        end
        name  = ($urandom_range(0, 9) == 0) ? 24'($urandom())
                                            : RESIDUE_NAME[$urandom_range(0, N_RESIDUES-1)];
        chain = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : sb.chain_sel;
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 21) : $urandom_range(22, 30);
        add_line(name, chain, (pick < 25) ? $urandom_range(1, 11) : 0, len, how);
    endfunction

    task automatic send_feed();
        t_text_item it;
        while (feed_q.size() != 0) begin
            it = feed_q.pop_front();
            if (idle_en && $urandom_range(0, 5) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_text_byte <= it.text;
            i_file_end  <= it.last_of_file;
            do @(posedge i_clk); while (!o_ready);
            sb.note_text_byte(it.text, it.last_of_file);
        end
        i_valid <= 1'b0;
    endtask

    // drain expected output, then allow for a line still in flight
    task automatic settle();
        while (sb.expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(logic [7:0] chain, logic abbrev);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= prce_pkg::REG_CHAIN;
        i_cfg_data  <= chain;
        @(posedge i_clk);
        sb.write_reg(prce_pkg::REG_CHAIN, chain);
        i_cfg_index <= prce_pkg::REG_ABBREV;
        i_cfg_data  <= {7'd0, abbrev};
        @(posedge i_clk);
        sb.write_reg(prce_pkg::REG_ABBREV, {7'd0, abbrev});
        i_cfg_wen <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_emitted_char(o_out_char, o_lookup_error, o_run_last);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        hold_done = 1'b0;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin
        idle_en  = 1'b1;
        hold_req = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_wen   <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_text_byte <= '0;
        i_file_end  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: chain A, three-letter names
        add_line("ALA", "A", 0, 24, END_LF);
        add_line("GLY", "B", 0, 23, END_LF);              // wrong chain
        add_line("SER", "A", -1, 23, END_LF);             // no keyword
        add_line("LYS", "A", 0, 21, END_LF);              // short, no chain column
        add_line({8'h00, 8'hFF, 8'h80}, "A", 0, 22, END_LF);
        add_line("TRP", "A", 22, 28, END_LF);             // keyword after the chain column
        push_text("ATOATOM  12345678MET A\n", 1'b0);      // restarted keyword match
        push_text("\n", 1'b0);
        add_line("VAL", "A", 0, 22, END_EOF);             // file ends without newline
        add_line("HIS", "A", 0, 25, END_LF_EOF);
        push_text("\n", 1'b1);
        feed_q.push_back(t_text_item'{8'hFF, 1'b1});
        send_feed();
        settle();

        set_config("A", 1'b1);
        add_line("GLY", "A", 0, 22, END_LF);
        add_line("XLE", "A", 0, 26, END_LF);
        add_line("XYZ", "A", 0, 22, END_LF);              // unknown name latches the error
        add_line("ALA", "A", 0, 22, END_LF);
        send_feed();
        settle();

        // error stays latched after the switch to three-letter names
        set_config("A", 1'b0);
        add_line("ALA", "A", 0, 22, END_LF);
        add_line("ALA", "A", 0, 22, END_LF_EOF);
        add_line("PRO", "A", 0, 22, END_LF);
        add_line("TRP", "A", 0, 24, END_OPEN);            // line left open across the write
        send_feed();
        settle();

        set_config(8'hFF, 1'b1);
        push_text("\n", 1'b0);
        add_line("CYS", 8'hFF, 0, 22, END_LF);
        add_line("CYS", "A", 0, 22, END_LF);
        send_feed();
        settle();

        set_config(8'h00, 1'b0);
        add_line("ASP", 8'h00, 0, 22, END_LF_EOF);
        add_line("ASP", 8'h00, 0, 21, END_LF);
        send_feed();

        for (int ph = 0; ph < 5; ph++) begin
            settle();
            case (ph)
                0:       set_config(8'($urandom_range(0, 255)), 1'b1);
                1:       set_config(8'hFF, 1'b0);
                2:       set_config(8'h00, 1'b0);
                3:       set_config("A", 1'b1);
                default: set_config(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            endcase
            idle_en = (ph != 4);
            if (ph == 2) begin
                // matching lines while the output is held, so the job queue fills
                for (int n = 0; n < 6; n++)
                    add_line(RESIDUE_NAME[$urandom_range(0, N_RESIDUES-1)], 8'h00, 0, 22,
                             END_LF);
                hold_req = 1'b1;
            end
            while (feed_q.size() < 10)
                add_random_line();
            send_feed();
        end

        while (sb.expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
